// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds through reset.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/tfilt_pkg.sv =====
package tfilt_pkg;

    // Telnet command and option bytes
    localparam logic [7:0] IAC           = 8'd255;
    localparam logic [7:0] CMD_DONT      = 8'd254;
    localparam logic [7:0] CMD_DO        = 8'd253;
    localparam logic [7:0] CMD_WONT      = 8'd252;
    localparam logic [7:0] CMD_WILL      = 8'd251;
    localparam logic [7:0] CMD_SB        = 8'd250;
    localparam logic [7:0] CMD_SE        = 8'd240;
    localparam logic [7:0] OPT_ECHO      = 8'd1;
    localparam logic [7:0] OPT_SUPP      = 8'd3;
    localparam logic [7:0] OPT_TERM      = 8'd24;
    localparam logic [7:0] TT_SEND       = 8'd1;
    localparam logic [7:0] TT_IS         = 8'd0;
    localparam logic [7:0] ESC_CHAR      = 8'd27;
    localparam logic [7:0] ESC_END_ABOVE = 8'd34;

    // Parser states
    localparam logic [1:0] PS_DATA = 2'd0;
    localparam logic [1:0] PS_CMD  = 2'd1;
    localparam logic [1:0] PS_OPT  = 2'd2;

    // Pending verb codes
    localparam logic [2:0] V_SB   = 3'd0;
    localparam logic [2:0] V_WILL = 3'd1;
    localparam logic [2:0] V_WONT = 3'd2;
    localparam logic [2:0] V_DO   = 3'd3;
    localparam logic [2:0] V_DONT = 3'd4;

    // Byte sinks
    localparam logic [1:0] SK_NVT     = 2'd0;
    localparam logic [1:0] SK_ANSI    = 2'd1;
    localparam logic [1:0] SK_TERM    = 2'd2;
    localparam logic [1:0] SK_DISCARD = 2'd3;

    // ANSI escape parser
    localparam logic [1:0] ES_NORMAL = 2'd0;
    localparam logic [1:0] ES_AFTER  = 2'd1;
    localparam logic [1:0] ES_SEQ    = 2'd2;

    // Job kinds passed from front to back
    localparam logic [1:0] JK_DATA  = 2'd0;
    localparam logic [1:0] JK_REPLY = 2'd1;
    localparam logic [1:0] JK_TERM  = 2'd2;

    localparam int TERMINAL_COUNT_DEF = 2;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam int IDX_W = 4;   // item index within a job, up to 10 items

    typedef struct packed {
        logic [1:0] kind;
        logic       ansi;   // terminal reply names ANSI, else NVT
        logic [7:0] b0;     // payload byte or reply verb
        logic [7:0] b1;     // reply option
    } t_job;

    function automatic logic [IDX_W-1:0] job_last_idx(input t_job j);
        logic [IDX_W-1:0] r;
        case (j.kind)
            JK_DATA:  r = IDX_W'(0);
            JK_REPLY: r = IDX_W'(2);
            JK_TERM:  r = j.ansi ? IDX_W'(9) : IDX_W'(8);
            default:  r = IDX_W'(0);
        endcase
        return r;
    endfunction

    // IAC SB 24 IS <name> IAC SE
    function automatic logic [7:0] term_byte(input logic ansi, input logic [IDX_W-1:0] idx);
        logic [7:0] r;
        case (idx)
            4'd0:    r = IAC;
            4'd1:    r = CMD_SB;
            4'd2:    r = OPT_TERM;
            4'd3:    r = TT_IS;
            4'd4:    r = ansi ? 8'h41 : 8'h4E;
            4'd5:    r = ansi ? 8'h4E : 8'h56;
            4'd6:    r = ansi ? 8'h53 : 8'h54;
            4'd7:    r = ansi ? 8'h49 : IAC;
            4'd8:    r = ansi ? IAC : CMD_SE;
            default: r = CMD_SE;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/tfilt_rx_if.sv =====
interface tfilt_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== hdl/tfilt_tx_if.sv =====
interface tfilt_tx_if;
    logic       valid;
    logic       ready;
    logic       channel;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output channel, output out_byte, output last, input ready);
    modport sink   (input valid, input channel, input out_byte, input last, output ready);
endinterface

// ===== hdl/telnet_receive_filter_core.sv =====
// A payload byte accepted on i_rx is written to the job queue, then loaded into the
// output register, from which it is presented on o_tx.
// Throughput: one payload item per cycle while o_tx is ready; a reply job is expanded
// into 3 items (option reply) or 9/10 items (terminal-type reply), one item a cycle.
// i_rx stalls only when the 4-entry job queue is full.
// Reset: i_rst_n synchronous, active low; parser back to data state, NVT sink,
// terminal index zero, queue emptied, output stage invalid.
module telnet_receive_filter_core import tfilt_pkg::*; #(
    parameter int TERMINAL_COUNT = TERMINAL_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tfilt_rx_if.sink    i_rx,
    tfilt_tx_if.source  o_tx
);

    // Front: IAC parser, sinks, option decisions. Emits one job per byte
    // that produces output. State moves on the accept edge.
    logic front_push;
    t_job front_job;
    logic q_full;

    // Queue: decouples parse from item expansion.
    logic q_empty;
    logic back_pop;
    t_job q_head;

    tfilt_front #(
        .TERMINAL_COUNT (TERMINAL_COUNT)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_rx.valid),
        .i_rx_byte (i_rx.rx_byte),
        .o_ready   (i_rx.ready),
        .i_full    (q_full),
        .o_push    (front_push),
        .o_job     (front_job)
    );

    tfilt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (back_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // Back: walks each job one item a cycle, while o_tx is not stalled, into a registered
    // output stage; the final item of a job carries last and pops the queue.
    tfilt_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (q_empty),
        .i_head     (q_head),
        .o_pop      (back_pop),
        .o_valid    (o_tx.valid),
        .i_ready    (o_tx.ready),
        .o_channel  (o_tx.channel),
        .o_out_byte (o_tx.out_byte),
        .o_last     (o_tx.last)
    );

endmodule

// ===== hdl/tfilt_front.sv =====
module tfilt_front import tfilt_pkg::*; #(
    parameter int TERMINAL_COUNT = TERMINAL_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_rx_byte,
    output logic       o_ready,
    input  logic       i_full,
    output logic       o_push,
    output t_job       o_job
);

    localparam logic [1:0] TC = 2'(TERMINAL_COUNT);

    logic [1:0] r_parse, n_parse;
    logic [2:0] r_verb,  n_verb;
    logic [1:0] r_sink,  n_sink;
    logic [1:0] r_tidx,  n_tidx;
    logic [1:0] r_esc,   n_esc;

    logic       fire;
    logic       do_sink;
    logic       has_job;
    logic [1:0] sel_cur;
    logic [1:0] sel_new;
    logic [7:0] b;

    assign o_ready = !i_full;
    assign fire    = i_valid && o_ready;
    assign b       = i_rx_byte;
    assign sel_cur = (r_tidx >= TC) ? TC - 2'd1 : r_tidx;
    assign sel_new = (n_tidx >= TC) ? TC - 2'd1 : n_tidx;
    assign o_push  = fire && has_job;

    always_comb begin
        n_parse = PS_DATA;
        n_verb  = r_verb;
        n_sink  = r_sink;
        n_tidx  = r_tidx;
        n_esc   = r_esc;
        do_sink = 1'b0;
        has_job = 1'b0;
        o_job   = '0;

        case (r_parse)
            PS_CMD: begin
                case (b)
                    IAC:      do_sink = 1'b1;
                    CMD_SE:   n_sink = (sel_cur == 2'd0) ? SK_NVT : SK_ANSI;
                    CMD_SB:   begin n_verb = V_SB;   n_parse = PS_OPT; end
                    CMD_WILL: begin n_verb = V_WILL; n_parse = PS_OPT; end
                    CMD_WONT: begin n_verb = V_WONT; n_parse = PS_OPT; end
                    CMD_DO:   begin n_verb = V_DO;   n_parse = PS_OPT; end
                    CMD_DONT: begin n_verb = V_DONT; n_parse = PS_OPT; end
                    default:  ;
                endcase
            end
            PS_OPT: begin
                o_job.kind = JK_REPLY;
                o_job.b1   = b;
                if (r_verb < V_WILL || r_verb > V_DONT) begin
                    n_sink = (b == OPT_TERM) ? SK_TERM : SK_DISCARD;
                end else if (b == OPT_ECHO) begin
                    has_job  = 1'b1;
                    o_job.b0 = (r_verb == V_WILL) ? CMD_DO :
                               (r_verb == V_WONT) ? CMD_DONT : CMD_WONT;
                end else if (b == OPT_SUPP) begin
                    has_job = 1'b0;
                end else if (r_verb == V_WILL) begin
                    has_job  = 1'b1;
                    o_job.b0 = CMD_DONT;
                end else if (r_verb == V_DO) begin
                    has_job  = 1'b1;
                    o_job.b0 = (b == OPT_TERM) ? CMD_WILL : CMD_WONT;
                end
            end
            default: begin
                if (b == IAC) n_parse = PS_CMD;
                else          do_sink = 1'b1;
            end
        endcase

        if (do_sink) begin
            case (r_sink)
                SK_NVT: begin
                    if (b != 8'd0) begin
                        has_job    = 1'b1;
                        o_job.kind = JK_DATA;
                        o_job.b0   = b;
                    end
                end
                SK_ANSI: begin
                    if (r_esc == ES_AFTER) begin
                        n_esc = ES_SEQ;
                    end else if (r_esc == ES_SEQ) begin
                        if (b > ESC_END_ABOVE) n_esc = ES_NORMAL;
                    end else begin
                        n_esc = ES_NORMAL;
                        if (b == ESC_CHAR) begin
                            n_esc = ES_AFTER;
                        end else if (b != 8'd0) begin
                            has_job    = 1'b1;
                            o_job.kind = JK_DATA;
                            o_job.b0   = b;
                        end
                    end
                end
                SK_TERM: begin
                    if (b == TT_SEND) begin
                        n_tidx     = (r_tidx >= TC) ? 2'd0 : r_tidx + 2'd1;
                        has_job    = 1'b1;
                        o_job.kind = JK_TERM;
                    end
                end
                default: ;
            endcase
        end
        o_job.ansi = (sel_new != 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parse <= PS_DATA;
            r_verb  <= V_SB;
            r_sink  <= SK_NVT;
            r_tidx  <= 2'd0;
            r_esc   <= ES_NORMAL;
        end else if (fire) begin
            r_parse <= n_parse;
            r_verb  <= n_verb;
            r_sink  <= n_sink;
            r_tidx  <= n_tidx;
            r_esc   <= n_esc;
        end
    end

endmodule

// ===== hdl/tfilt_queue.sv =====
module tfilt_queue import tfilt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_head
);

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr;
    logic [Q_PTR_W-1:0] r_rptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               do_pop;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wptr <= r_wptr + Q_PTR_W'(1);
            if (do_pop) r_rptr <= r_rptr + Q_PTR_W'(1);
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + Q_CNT_W'(1);
                2'b01:   r_count <= r_count - Q_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hdl/tfilt_back.sv =====
module tfilt_back import tfilt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_job       i_head,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_channel,
    output logic [7:0] o_out_byte,
    output logic       o_last
);

    logic [IDX_W-1:0] r_idx;
    logic             r_valid;
    logic             r_channel;
    logic [7:0]       r_byte;
    logic             r_last;
    logic             load;
    logic             is_last;
    logic [7:0]       cur_byte;

    assign load    = !i_empty && (!r_valid || i_ready);
    assign is_last = (r_idx == job_last_idx(i_head));
    assign o_pop   = load && is_last;

    always_comb begin
        case (i_head.kind)
            JK_DATA: cur_byte = i_head.b0;
            JK_REPLY: begin
                case (r_idx)
                    4'd0:    cur_byte = IAC;
                    4'd1:    cur_byte = i_head.b0;
                    default: cur_byte = i_head.b1;
                endcase
            end
            JK_TERM: cur_byte = term_byte(i_head.ansi, r_idx);
            default: cur_byte = i_head.b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= is_last ? '0 : r_idx + IDX_W'(1);
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_channel <= (i_head.kind != JK_DATA);
            r_byte    <= cur_byte;
            r_last    <= is_last;
        end
    end

    assign o_valid    = r_valid;
    assign o_channel  = r_channel;
    assign o_out_byte = r_byte;
    assign o_last     = r_last;

endmodule

// ===== hdl/tfilt_checker.sv =====
`include "assert_macros.svh"

module tfilt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_tx_valid,
    input logic       i_tx_ready,
    input logic       i_tx_channel,
    input logic [7:0] i_tx_out_byte,
    input logic       i_tx_last
);

    // stalled item holds
    `ASSERT_NEXT(a_tx_hold, i_clk, i_rst_n, i_tx_valid && !i_tx_ready, i_tx_valid && $stable(i_tx_out_byte) && $stable(i_tx_channel) && $stable(i_tx_last), "tx item changed while stalled")

    // payload items stand alone
    `ASSERT_IMPLY(a_data_last, i_clk, i_rst_n, i_tx_valid && !i_tx_channel, i_tx_last, "payload item without last")

    // a reply run is not broken by payload
    `ASSERT_NEXT(a_reply_run, i_clk, i_rst_n, i_tx_valid && i_tx_ready && i_tx_channel && !i_tx_last, !i_tx_valid || i_tx_channel, "reply run interrupted")

    // output empty after reset
    `ASSERT_NEXT_ALWAYS(a_rst_idle, i_clk, !i_rst_n, !i_tx_valid, "tx valid after reset")

endmodule

bind telnet_receive_filter_core tfilt_checker u_tfilt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_tx_valid    (o_tx.valid),
    .i_tx_ready    (o_tx.ready),
    .i_tx_channel  (o_tx.channel),
    .i_tx_out_byte (o_tx.out_byte),
    .i_tx_last     (o_tx.last)
);

// ===== test/tb_telnet_receive_filter_core.sv =====
`timescale 1ns / 100ps

module tb_telnet_receive_filter_core;
    import tfilt_pkg::*;

    localparam int TERM_COUNT = TERMINAL_COUNT_DEF;
    localparam int RANDOM_ITEMS = 243;

    // Opening bytes: null and plain payload, doubled IAC, echo and
    // terminal-type negotiation, an unknown option, a terminal-type SEND
    // that switches the payload path to ANSI, an escape sequence, and an
    // unknown command after IAC.
    localparam logic [7:0] DIRECTED [27] = '{
        8'h00, 8'h41,
        IAC, IAC,
        IAC, CMD_WILL, OPT_ECHO,
        IAC, CMD_DO, OPT_TERM,
        IAC, CMD_WILL, 8'd200,
        IAC, CMD_SB, OPT_TERM, TT_SEND, IAC, CMD_SE,
        ESC_CHAR, 8'h5B, 8'h31, 8'h6D, 8'h78,
        IAC, 8'd241,
        8'h7F
    };

    typedef struct packed {
        logic       channel;
        logic [7:0] out_byte;
        logic       last;
    } t_out_item;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    tfilt_rx_if rx_if ();
    tfilt_tx_if tx_if ();

    telnet_receive_filter_core #(
        .TERMINAL_COUNT (TERM_COUNT)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_tx    (tx_if)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Filter model state
    // ------------------------------------------------------------------
    logic [1:0] m_parse;
    logic [2:0] m_verb;
    logic [1:0] m_sink;
    logic [1:0] m_term_idx;
    logic [1:0] m_esc;

    t_out_item  expected_out [$];   // bytes the block still owes, oldest first
    t_out_item  byte_out     [$];   // results of the byte being modeled
    logic [7:0] rx_pending   [$];   // bytes not yet offered

    int fails     = 0;
    int items_in  = 0;
    int items_out = 0;
    int total_in  = 0;
    int send_gap  = 0;
    int recv_stall = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    t_out_item seen_item;
    t_out_item want_item;

    function automatic logic [1:0] selected_terminal();
        return (m_term_idx >= TERM_COUNT) ? 2'(TERM_COUNT - 1) : m_term_idx;
    endfunction

    task automatic emit(input logic ch, input logic [7:0] b);
        t_out_item it;
        it.channel  = ch;
        it.out_byte = b;
        it.last     = 1'b0;
        byte_out.push_back(it);
    endtask

    task automatic emit_reply(input logic [7:0] verb, input logic [7:0] opt);
        emit(1'b1, IAC);
        emit(1'b1, verb);
        emit(1'b1, opt);
    endtask

    // Byte handed to whichever sink is selected.
    task automatic sink_byte(input logic [7:0] b);
        string nm;
        int    i;
        case (m_sink)
            SK_NVT: begin
                if (b != 8'd0) emit(1'b0, b);
            end
            SK_ANSI: begin
                // escape state survives sink changes
                if (m_esc == ES_AFTER) begin
                    m_esc = ES_SEQ;
                end else if (m_esc == ES_SEQ) begin
                    if (b > ESC_END_ABOVE) m_esc = ES_NORMAL;
                end else begin
                    m_esc = ES_NORMAL;
                    if (b == ESC_CHAR) m_esc = ES_AFTER;
                    else if (b != 8'd0) emit(1'b0, b);
                end
            end
            SK_TERM: begin
                if (b == TT_SEND) begin
                    m_term_idx = (m_term_idx >= TERM_COUNT) ? 2'd0 : m_term_idx + 2'd1;
                    nm = (selected_terminal() == 2'd0) ? "NVT" : "ANSI";
                    emit(1'b1, IAC);
                    emit(1'b1, CMD_SB);
                    emit(1'b1, OPT_TERM);
                    emit(1'b1, TT_IS);
                    for (i = 0; i < nm.len(); i++) emit(1'b1, nm[i]);
                    emit(1'b1, IAC);
                    emit(1'b1, CMD_SE);
                end
            end
            default: ;  // discard subnegotiation without handler
        endcase
    endtask

    task automatic option_byte(input logic [7:0] opt);
        if (m_verb < V_WILL || m_verb > V_DONT) begin
            // IAC SB <opt>: point the sink at the option's handler
            m_sink = (opt == OPT_TERM) ? SK_TERM : SK_DISCARD;
            return;
        end
        if (opt == OPT_ECHO) begin
            if (m_verb == V_WILL)      emit_reply(CMD_DO, opt);
            else if (m_verb == V_WONT) emit_reply(CMD_DONT, opt);
            else                       emit_reply(CMD_WONT, opt);
        end else if (opt == OPT_SUPP) begin
            // suppress-go-ahead: silent
        end else if (opt == OPT_TERM) begin
            if (m_verb == V_WILL)    emit_reply(CMD_DONT, opt);
            else if (m_verb == V_DO) emit_reply(CMD_WILL, opt);
        end else begin
            if (m_verb == V_WILL)    emit_reply(CMD_DONT, opt);
            else if (m_verb == V_DO) emit_reply(CMD_WONT, opt);
        end
    endtask

    // Runs one received byte through the model and queues what it causes.
    task automatic filter_rx_byte(input logic [7:0] b);
        int i;
        byte_out.delete();
        case (m_parse)
            PS_CMD: begin
                m_parse = PS_DATA;
                case (b)
                    IAC:      sink_byte(b);
                    CMD_SE:   m_sink = (selected_terminal() == 2'd0) ? SK_NVT : SK_ANSI;
                    CMD_SB:   begin m_verb = V_SB;   m_parse = PS_OPT; end
                    CMD_WILL: begin m_verb = V_WILL; m_parse = PS_OPT; end
                    CMD_WONT: begin m_verb = V_WONT; m_parse = PS_OPT; end
                    CMD_DO:   begin m_verb = V_DO;   m_parse = PS_OPT; end
                    CMD_DONT: begin m_verb = V_DONT; m_parse = PS_OPT; end
                    default: ;  // unknown command, ignored
                endcase
            end
            PS_OPT: begin
                m_parse = PS_DATA;
                option_byte(b);
            end
            default: begin
                m_parse = PS_DATA;
                if (b == IAC) m_parse = PS_CMD;
                else sink_byte(b);
            end
        endcase
        if (byte_out.size() > 0) byte_out[byte_out.size() - 1].last = 1'b1;
        for (i = 0; i < byte_out.size(); i++) expected_out.push_back(byte_out[i]);
    endtask

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    function automatic logic [7:0] pick_data();
        return ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(254));
    endfunction

    function automatic logic [7:0] pick_option();
        case ($urandom_range(4))
            0:       return OPT_ECHO;
            1:       return OPT_SUPP;
            2:       return OPT_TERM;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] pick_verb();
        case ($urandom_range(3))
            0:       return CMD_WILL;
            1:       return CMD_WONT;
            2:       return CMD_DO;
            default: return CMD_DONT;
        endcase
    endfunction

    // Mostly well-formed telnet traffic with random content, some noise.
    task automatic add_random_sequence();
        int k, n, i;
        logic [7:0] opt;
        k = $urandom_range(99);
        if (k < 28) begin
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++) rx_pending.push_back(pick_data());
        end else if (k < 36) begin
            rx_pending.push_back(IAC);
            rx_pending.push_back(IAC);
        end else if (k < 58) begin
            rx_pending.push_back(IAC);
            rx_pending.push_back(pick_verb());
            rx_pending.push_back(pick_option());
        end else if (k < 70) begin
            // terminal-type subnegotiation, usually carrying SEND
            rx_pending.push_back(IAC);
            rx_pending.push_back(CMD_SB);
            rx_pending.push_back(OPT_TERM);
            n = $urandom_range(0, 3);
            for (i = 0; i < n; i++) begin
                rx_pending.push_back(($urandom_range(2) != 0) ? TT_SEND : pick_data());
            end
            rx_pending.push_back(IAC);
            rx_pending.push_back(CMD_SE);
        end else if (k < 78) begin
            // subnegotiation for an option with no handler
            opt = 8'($urandom_range(255));
            if (opt == OPT_TERM) opt = OPT_ECHO;
            rx_pending.push_back(IAC);
            rx_pending.push_back(CMD_SB);
            rx_pending.push_back(opt);
            n = $urandom_range(0, 4);
            for (i = 0; i < n; i++) rx_pending.push_back(pick_data());
            rx_pending.push_back(IAC);
            rx_pending.push_back(CMD_SE);
        end else if (k < 90) begin
            // escape sequence: ESC, eaten byte, parameters, final byte, text
            rx_pending.push_back(ESC_CHAR);
            rx_pending.push_back(pick_data());
            n = $urandom_range(0, 3);
            for (i = 0; i < n; i++) rx_pending.push_back(8'($urandom_range(34)));
            rx_pending.push_back(8'($urandom_range(35, 254)));
            rx_pending.push_back(pick_data());
        end else if (k < 95) begin
            rx_pending.push_back(IAC);
            rx_pending.push_back(8'($urandom_range(255)));
        end else begin
            rx_pending.push_back(8'($urandom_range(255)));
        end
    endtask

    // Idle lengths: mostly none, some short, a few long.
    function automatic int pick_gap(input bit eager);
        int r;
        r = $urandom_range(99);
        if (eager || r < 65) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers queued bytes, models each one as it is accepted
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_if.valid <= 1'b0;
        end else begin
            if (rx_if.valid && rx_if.ready) begin
                filter_rx_byte(rx_if.rx_byte);
                items_in <= items_in + 1;
            end
            if (!rx_if.valid || rx_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    rx_if.valid <= 1'b0;
                end else if (rx_pending.size() > 0) begin
                    rx_if.valid   <= 1'b1;
                    rx_if.rx_byte <= rx_pending.pop_front();
                    send_gap = pick_gap((items_in / 48) % 3 == 1);
                end else begin
                    rx_if.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, once, well into the run: the job queue fills
    // and the input must stall while the driver keeps offering.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && items_in >= 110) begin
            hold_left <= 300;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each accepted output item against the oldest one owed
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tx_if.ready <= 1'b0;
        end else begin
            if (tx_if.valid && tx_if.ready) begin
                items_out++;
                seen_item.channel  = tx_if.channel;
                seen_item.out_byte = tx_if.out_byte;
                seen_item.last     = tx_if.last;
                if (expected_out.size() == 0) begin
                    $display("%0t: unexpected item ch=%0d byte=%0d last=%0d", $time,
                             seen_item.channel, seen_item.out_byte, seen_item.last);
                    fails++;
                end else begin
                    want_item = expected_out.pop_front();
                    if (seen_item.channel !== want_item.channel ||
                        seen_item.out_byte !== want_item.out_byte ||
                        seen_item.last !== want_item.last) begin
                        $display("%0t: mismatch expected ch=%0d byte=%0d last=%0d, got ch=%0d byte=%0d last=%0d",
                                 $time, want_item.channel, want_item.out_byte,
                                 want_item.last, seen_item.channel,
                                 seen_item.out_byte, seen_item.last);
                        fails++;
                    end
                end
            end
            if (hold_left > 0) begin
                tx_if.ready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                tx_if.ready <= 1'b0;
            end else begin
                tx_if.ready <= 1'b1;
                recv_stall = pick_gap((items_out / 48) % 3 == 2);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------
    initial begin
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = 8'd0;
        tx_if.ready   = 1'b0;

        m_parse    = PS_DATA;
        m_verb     = V_SB;
        m_sink     = SK_NVT;
        m_term_idx = 2'd0;
        m_esc      = ES_NORMAL;

        foreach (DIRECTED[i]) rx_pending.push_back(DIRECTED[i]);
        while (rx_pending.size() < $size(DIRECTED) + RANDOM_ITEMS) add_random_sequence();
        total_in = rx_pending.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every byte accepted and modeled, then everything owed delivered
        while (items_in < total_in) @(posedge i_clk);
        while (expected_out.size() > 0) @(posedge i_clk);
        // drain: catch any extra items still in flight
        repeat (30) @(posedge i_clk);

        if (expected_out.size() != 0) begin
            $display("%0t: %0d expected items never arrived", $time, expected_out.size());
            fails++;
        end
        if (fails == 0) begin
            $display("telnet_receive_filter_core regression: pass");
        end else begin
            $display("telnet_receive_filter_core regression: fail");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("telnet_receive_filter_core regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/tfilt_pkg.sv
hdl/tfilt_rx_if.sv
hdl/tfilt_tx_if.sv
hdl/tfilt_front.sv
hdl/tfilt_queue.sv
hdl/tfilt_back.sv
hdl/telnet_receive_filter_core.sv
hdl/tfilt_checker.sv
test/tb_telnet_receive_filter_core.sv
